/* src/task_runtime_accounting_table_unit_macros.svh */
// ----------------------------------------------------------------------------
// Task runtime accounting table: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TASK_RUNTIME_ACCOUNTING_TABLE_UNIT_MACROS_SVH
`define TASK_RUNTIME_ACCOUNTING_TABLE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TRAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/trat_pkg.sv */
// ----------------------------------------------------------------------------
// Task runtime accounting table: package
// Sizes, command codes and the payload and control types of the block.
// ----------------------------------------------------------------------------
package trat_pkg;

  localparam int MAX_TASKS    = 8;
  localparam int TASK_ID_BITS = 16;

  // Stored ids keep only the bits that survive both the port and the id width.
  localparam int ID_W    = (TASK_ID_BITS < 16) ? TASK_ID_BITS : 16;
  localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W   = $clog2(MAX_TASKS + 1);
  localparam int RUN_W   = 64;
  localparam int STAMP_W = 32;
  localparam int TOT_W   = RUN_W + $clog2(MAX_TASKS);
  localparam int SCALE   = 10000;
  localparam int SHARE_W = 14;
  localparam int PROD_W  = RUN_W + SHARE_W;

  localparam logic [1:0] CMD_SWITCH_IN  = 2'd0;
  localparam logic [1:0] CMD_SWITCH_OUT = 2'd1;
  localparam logic [1:0] CMD_SNAPSHOT   = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] task_id;
    logic [31:0] timestamp;
    logic [2:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] entry_task;
    logic [31:0] switch_total;
    logic [63:0] entry_runtime;
    logic [13:0] usage_basis_points;
    logic [3:0]  registered_count;
  } result_t;

  typedef struct packed {
    logic               start;
    logic [RUN_W-1:0]   part;
    logic [TOT_W-1:0]   total;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SHARE_W-1:0] share;
  } div_rsp_t;

endpackage

/* src/trat_item_if.sv */
// ----------------------------------------------------------------------------
// Task runtime accounting table: input channel
// Valid/ready channel that carries one event or query per transfer.
// ----------------------------------------------------------------------------
interface trat_item_if;
  import trat_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/trat_result_if.sv */
// ----------------------------------------------------------------------------
// Task runtime accounting table: result channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface trat_result_if;
  import trat_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/trat_share_div.sv */
// ----------------------------------------------------------------------------
// Task runtime accounting table: share unit
// Computes floor(part * 10000 / total) with one shared 32x14 multiplier and a
// restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trat_share_div (
  input  logic              clk,
  input  logic              rst,
  input  trat_pkg::div_req_t req,
  output trat_pkg::div_rsp_t rsp
);
  import trat_pkg::*;

  localparam int DVS_W  = TOT_W + SHARE_W - 1;
  localparam int CMP_W  = (PROD_W > DVS_W) ? PROD_W : DVS_W;
  localparam int HALF_W = RUN_W / 2;
  localparam int MUL_W  = HALF_W + SHARE_W;
  localparam int STEP_W = $clog2(SHARE_W);
  localparam logic [SHARE_W-1:0] SCALE_K = SHARE_W'(SCALE);

  typedef enum logic [2:0] {D_IDLE, D_MUL_LO, D_MUL_HI, D_DIV, D_DONE} dstate_t;

  dstate_t            state;
  logic [RUN_W-1:0]   part_q;
  logic [PROD_W-1:0]  rem;
  logic [DVS_W-1:0]   dvs;
  logic [SHARE_W-1:0] quo;
  logic [STEP_W-1:0]  step;
  logic [HALF_W-1:0]  mul_in;
  logic [MUL_W-1:0]   mul_out;
  logic               ge;

  assign mul_in  = (state == D_MUL_LO) ? part_q[HALF_W-1:0] : part_q[RUN_W-1:HALF_W];
  assign mul_out = MUL_W'(mul_in) * MUL_W'(SCALE_K);
  assign ge      = CMP_W'(rem) >= CMP_W'(dvs);

  assign rsp.done  = (state == D_DONE);
  assign rsp.share = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            part_q <= req.part;
            dvs    <= DVS_W'(req.total) << (SHARE_W - 1);
            quo    <= '0;
            step   <= STEP_W'(SHARE_W - 1);
            // A zero total gives a zero share.
            state  <= (req.total == '0) ? D_DONE : D_MUL_LO;
          end
        end
        D_MUL_LO: begin
          rem   <= PROD_W'(mul_out);
          state <= D_MUL_HI;
        end
        D_MUL_HI: begin
          rem   <= rem + PROD_W'({mul_out, {HALF_W{1'b0}}});
          state <= D_DIV;
        end
        D_DIV: begin
          if (ge) begin
            rem <= rem - PROD_W'(dvs);
          end
          quo  <= {quo[SHARE_W-2:0], ge};
          dvs  <= dvs >> 1;
          step <= step - STEP_W'(1);
          if (step == '0) begin
            state <= D_DONE;
          end
        end
        D_DONE: begin
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end
endmodule

/* src/task_runtime_accounting_table_unit.sv */
// ----------------------------------------------------------------------------
// Task runtime accounting table
// Per-task runtime statistics: switch-in, switch-out and snapshot queries.
// ----------------------------------------------------------------------------
// The unit takes one command per transfer and returns exactly one result per
// command. Commands are handled one at a time by a small sequencer. A lookup
// in S_SCAN walks the table one entry per cycle until it finds the id or
// reaches the end of the entries in use; a switch-in then restamps a known
// entry, claims a new one or is refused, and a switch-out of a known id
// closes its interval in S_ACC. A null switch-in id, a snapshot index past
// the entries in use or an undefined command goes straight to S_DONE. A
// snapshot visits each entry in use through S_ELAP, S_RUN and S_SUM, starts
// the share unit in S_DIV_GO, waits in S_SHARE while the share unit runs two
// multiply steps, fourteen divide steps and one handoff (only the handoff
// when the total is zero), and then loads the result in S_DONE. The input
// channel is ready whenever the sequencer is idle, which is from the cycle
// after the result is loaded. A finished result waits in an output register,
// so a new command can be taken while the previous result has not yet been
// collected; only a result that is still waiting when the next one is ready
// holds the sequencer.
module task_runtime_accounting_table_unit (
  input logic           clk,
  input logic           rst,
  trat_item_if.sink     item,
  trat_result_if.source result
);
  import trat_pkg::*;

  localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;

  // S_SCAN looks up the id, S_ACC closes an interval on switch-out, and the
  // S_ELAP / S_RUN / S_SUM triple visits each entry during a snapshot.
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_ACC, S_ELAP, S_RUN, S_SUM, S_DIV_GO, S_SHARE, S_DONE
  } state_t;

  state_t state;

  // Latched command.
  logic [1:0]         cmd_q;
  logic [ID_W-1:0]    id_q;
  logic [STAMP_W-1:0] now_q;
  logic [2:0]         idx_q;

  // Table storage. Entries at or above used_entries are never read, so the
  // arrays need no clearing; a new entry is initialized when it is claimed.
  logic [ID_W-1:0]    entry_ids          [MAX_TASKS];
  logic [RUN_W-1:0]   accumulated_cycles [MAX_TASKS];
  logic [STAMP_W-1:0] start_stamps       [MAX_TASKS];
  logic [31:0]        switch_counts      [MAX_TASKS];
  logic [CNT_W-1:0]   used_entries;

  // Walk pointer and datapath registers.
  logic [CNT_W-1:0]   ptr;
  logic [STAMP_W-1:0] elapsed;
  logic [RUN_W-1:0]   run_q;
  logic [TOT_W-1:0]   total;

  // Fields of the result under construction.
  logic               fail_q;
  logic [15:0]        e_task;
  logic [31:0]        e_sw;
  logic [RUN_W-1:0]   e_run;
  logic [SHARE_W-1:0] e_bp;

  result_t out_q;
  logic    out_valid;
  logic    out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [IDX_W-1:0]   slot;
  logic [ID_W-1:0]    in_id;
  logic               id_hit;
  logic               scan_end;
  logic               last_entry;
  logic               idx_hit;
  logic               idx_fail;
  logic [STAMP_W-1:0] elapsed_now;
  logic [RUN_W-1:0]   run_sum;

  assign slot        = ptr[IDX_W-1:0];
  assign in_id       = ID_W'(item.data.task_id);
  assign id_hit      = (entry_ids[slot] == id_q);
  assign scan_end    = (ptr == used_entries);
  assign last_entry  = (ptr == used_entries - CNT_W'(1));
  assign idx_hit     = (CMP_W'(idx_q) == CMP_W'(ptr));
  assign idx_fail    = (CMP_W'(item.data.entry_index) >= CMP_W'(used_entries));
  // The open interval wraps to 32 bits, like the free-running counter.
  assign elapsed_now = now_q - start_stamps[slot];
  // One adder serves both the switch-out update and the snapshot runtime.
  assign run_sum     = accumulated_cycles[slot] + RUN_W'(elapsed);

  // The finished result moves into the output register once that register
  // is free or is being emptied in this cycle.
  assign out_load    = (state == S_DONE) && (!out_valid || result.ready);

  assign item.ready   = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.data  = out_q;

  assign div_req.start = (state == S_DIV_GO);
  assign div_req.part  = e_run;
  assign div_req.total = total;

  trat_share_div u_share (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used_entries <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            cmd_q  <= item.data.command;
            id_q   <= in_id;
            now_q  <= item.data.timestamp;
            idx_q  <= item.data.entry_index;
            ptr    <= '0;
            total  <= '0;
            fail_q <= STATUS_OK;
            e_task <= '0;
            e_sw   <= '0;
            e_run  <= '0;
            e_bp   <= '0;
            unique case (item.data.command)
              CMD_SWITCH_IN: begin
                // The null id never enters the table.
                if (in_id == '0) begin
                  fail_q <= STATUS_FAIL;
                  state  <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_SWITCH_OUT: begin
                state <= S_SCAN;
              end
              CMD_SNAPSHOT: begin
                if (idx_fail) begin
                  fail_q <= STATUS_FAIL;
                  state  <= S_DONE;
                end else begin
                  state <= S_ELAP;
                end
              end
              default: begin
                fail_q <= STATUS_FAIL;
                state  <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (scan_end) begin
            // Id not in the table. A switch-in claims the next free entry;
            // an unknown switch-out is simply ignored.
            if (cmd_q == CMD_SWITCH_IN) begin
              if (used_entries == CNT_W'(MAX_TASKS)) begin
                fail_q <= STATUS_FAIL;
              end else begin
                entry_ids[slot]          <= id_q;
                accumulated_cycles[slot] <= '0;
                start_stamps[slot]       <= now_q;
                switch_counts[slot]      <= 32'd1;
                used_entries             <= used_entries + CNT_W'(1);
              end
            end
            state <= S_DONE;
          end else if (id_hit) begin
            if (cmd_q == CMD_SWITCH_IN) begin
              start_stamps[slot]  <= now_q;
              switch_counts[slot] <= switch_counts[slot] + 32'd1;
              state               <= S_DONE;
            end else begin
              elapsed <= elapsed_now;
              state   <= S_ACC;
            end
          end else begin
            ptr <= ptr + CNT_W'(1);
          end
        end

        S_ACC: begin
          accumulated_cycles[slot] <= run_sum;
          state                    <= S_DONE;
        end

        S_ELAP: begin
          // Only the running task has an open interval.
          elapsed <= id_hit ? elapsed_now : '0;
          state   <= S_RUN;
        end

        S_RUN: begin
          run_q <= run_sum;
          if (idx_hit) begin
            e_run  <= run_sum;
            e_task <= 16'(entry_ids[slot]);
            e_sw   <= switch_counts[slot];
          end
          state <= S_SUM;
        end

        S_SUM: begin
          total <= total + TOT_W'(run_q);
          if (last_entry) begin
            state <= S_DIV_GO;
          end else begin
            ptr   <= ptr + CNT_W'(1);
            state <= S_ELAP;
          end
        end

        S_DIV_GO: begin
          state <= S_SHARE;
        end

        S_SHARE: begin
          if (div_rsp.done) begin
            e_bp  <= div_rsp.share;
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // Load the output register once it is free or being emptied.
          if (out_load) begin
            out_q.status             <= fail_q;
            out_q.entry_task         <= e_task;
            out_q.switch_total       <= e_sw;
            out_q.entry_runtime      <= e_run;
            out_q.usage_basis_points <= e_bp;
            out_q.registered_count   <= 4'(used_entries);
            state                    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "task_runtime_accounting_table_unit_macros.svh"

  `TRAT_ASSERT_NOW(a_used_bound, 1'b1, used_entries <= CNT_W'(MAX_TASKS), "table overfilled")
  `TRAT_ASSERT_NEXT(a_busy_after_accept, item.valid && item.ready, state != S_IDLE, "not busy")
  `TRAT_ASSERT_NOW(a_share_range, result.valid,
                   result.data.usage_basis_points <= 14'd10000, "share range")
  `TRAT_ASSERT_NOW(a_fail_clears, result.valid && result.data.status == STATUS_FAIL,
                   result.data.entry_runtime == '0 && result.data.entry_task == '0,
                   "failed result not cleared")
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task runtime accounting table: testbench
// Drives switch-in, switch-out and snapshot commands into the unit and checks
// every result against a behavioral copy of the task table kept in a class.
// ----------------------------------------------------------------------------
module tb_top;
  import trat_pkg::*;

  // Command code 3 is not defined by the unit; it must fail and change nothing.
  localparam logic [1:0] CMD_UNDEFINED = 2'd3;

  // Phase length of the random part. Four phases give about 900 transfers.
  localparam int PHASE_ITEMS = 225;

  // A snapshot with a full table is the longest command. This many quiet
  // cycles after the last result leave room for any stray late result.
  localparam int DRAIN_CYCLES = 80;

  // --------------------------------------------------------------------------
  // Behavioral copy of the task table and the store of expected results.
  // --------------------------------------------------------------------------
  class runtime_scoreboard;
    logic [15:0] ids [MAX_TASKS];
    logic [63:0] cycles [MAX_TASKS];
    logic [31:0] stamps [MAX_TASKS];
    logic [31:0] switches [MAX_TASKS];
    int unsigned used;
    result_t     expected_results [$];
    int          mismatches;

    function new();
      for (int i = 0; i < MAX_TASKS; i++) begin
        ids[i]      = '0;
        cycles[i]   = '0;
        stamps[i]   = '0;
        switches[i] = '0;
      end
      used       = 0;
      mismatches = 0;
    endfunction

    // Only entries in use are searched, so id 0 is never found.
    function int find_slot(logic [15:0] id);
      for (int i = 0; i < used; i++) begin
        if (ids[i] == id) return i;
      end
      return -1;
    endfunction

    // Applies one command to the table and returns the result it must cause.
    function result_t predict_result(in_item_t it);
      result_t     r;
      int          slot;
      logic [31:0] elapsed;
      logic [63:0] run;
      logic [63:0] part;
      logic [79:0] sum;
      logic [79:0] scaled;
      r = '0;
      r.status = STATUS_OK;
      case (it.command)
        CMD_SWITCH_IN: begin
          if (it.task_id == '0) begin
            r.status = STATUS_FAIL;
          end else begin
            slot = find_slot(it.task_id);
            if (slot < 0) begin
              if (used >= MAX_TASKS) begin
                r.status = STATUS_FAIL;
              end else begin
                slot           = used;
                ids[slot]      = it.task_id;
                cycles[slot]   = '0;
                switches[slot] = '0;
                used++;
              end
            end
            if (slot >= 0) begin
              stamps[slot]   = it.timestamp;
              switches[slot] = switches[slot] + 32'd1;
            end
          end
        end
        CMD_SWITCH_OUT: begin
          // Unknown and null ids are silently ignored.
          slot = find_slot(it.task_id);
          if (slot >= 0) begin
            elapsed      = it.timestamp - stamps[slot];
            cycles[slot] = cycles[slot] + {32'd0, elapsed};
          end
        end
        CMD_SNAPSHOT: begin
          if (int'(it.entry_index) >= used) begin
            r.status = STATUS_FAIL;
          end else begin
            // The running task's open interval counts toward its own entry
            // and toward the total. The total is kept wider than 64 bits.
            sum  = '0;
            part = '0;
            for (int i = 0; i < used; i++) begin
              run = cycles[i];
              if (ids[i] == it.task_id) begin
                elapsed = it.timestamp - stamps[i];
                run     = run + {32'd0, elapsed};
              end
              sum = sum + {16'd0, run};
              if (i == int'(it.entry_index)) part = run;
            end
            r.entry_task    = ids[it.entry_index];
            r.switch_total  = switches[it.entry_index];
            r.entry_runtime = part;
            if (sum != '0) begin
              scaled = {16'd0, part} * 80'd10000;
              r.usage_basis_points = 14'(scaled / sum);
            end
          end
        end
        default: begin
          r.status = STATUS_FAIL;
        end
      endcase
      r.registered_count = 4'(used);
      return r;
    endfunction

    function void record_command(in_item_t it);
      expected_results.push_back(predict_result(it));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: no command outstanding");
        mismatches++;
        return;
      end
      exp_r = expected_results.pop_front();
      compare_field("status", 64'(exp_r.status), 64'(got.status));
      compare_field("entry_task", 64'(exp_r.entry_task), 64'(got.entry_task));
      compare_field("switch_total", 64'(exp_r.switch_total), 64'(got.switch_total));
      compare_field("entry_runtime", exp_r.entry_runtime, got.entry_runtime);
      compare_field("usage_basis_points", 64'(exp_r.usage_basis_points),
                    64'(got.usage_basis_points));
      compare_field("registered_count", 64'(exp_r.registered_count),
                    64'(got.registered_count));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the unit under test.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  trat_item_if   item_ch ();
  trat_result_if result_ch ();

  task_runtime_accounting_table_unit uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  runtime_scoreboard sb = new();

  // Percentages of cycles in which the sender idles and the receiver stalls.
  // The main sequence changes them from phase to phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Stimulus state for the random part: a cycle counter that only moves
  // forward (and wraps) and the task that is currently switched in.
  logic [31:0] clock_now;
  logic [15:0] running_task;

  // --------------------------------------------------------------------------
  // Result side. Values are sampled at the rising edge, before any
  // nonblocking update of this step lands, so a transfer is seen exactly as
  // the unit saw it. Ready is redrawn each cycle to place stalls at random.
  // --------------------------------------------------------------------------
  initial result_ch.ready = 1'b0;

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      sb.check_result(result_ch.data);
    end
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Command side.
  // --------------------------------------------------------------------------
  function automatic in_item_t make_item(logic [1:0] command, logic [15:0] task_id,
                                         logic [31:0] timestamp, logic [2:0] entry_index);
    in_item_t it;
    it.command     = command;
    it.task_id     = task_id;
    it.timestamp   = timestamp;
    it.entry_index = entry_index;
    return it;
  endfunction

  // The eight ids that fill the table in the directed part. Between them
  // every id bit is seen both high and low.
  function automatic logic [15:0] known_id(int k);
    case (k)
      0:       return 16'hFFFF;
      1:       return 16'h0001;
      2:       return 16'h8000;
      3:       return 16'h5A5A;
      4:       return 16'h00FF;
      5:       return 16'h1234;
      6:       return 16'h7FFF;
      default: return 16'hA5A5;
    endcase
  endfunction

  // Offers one command and returns at the edge where it is transferred.
  // A random gap comes first; valid is lowered only when a gap is taken, so
  // back-to-back commands keep valid high with no glitch in between. The
  // handshake is judged on values sampled at the edge itself.
  task automatic send_command(in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    sb.record_command(it);
  endtask

  // Holds the sender back until every expected result has been collected.
  task automatic wait_for_results();
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Edge cases first: an empty table, the null id, unknown ids, the undefined
  // command, wrapping intervals, a zero total, a full table and an index past
  // the entries in use.
  task automatic directed_commands();
    send_command(make_item(CMD_SNAPSHOT, 16'h0000, 32'h0000_0000, 3'd0));
    send_command(make_item(CMD_SWITCH_IN, 16'h0000, 32'h0000_0005, 3'd0));
    send_command(make_item(CMD_SWITCH_OUT, 16'h0042, 32'h0000_0006, 3'd0));
    send_command(make_item(CMD_UNDEFINED, 16'hFFFF, 32'hFFFF_FFFF, 3'd7));
    send_command(make_item(CMD_SWITCH_IN, 16'hFFFF, 32'hFFFF_FFF0, 3'd0));
    // Nothing has run yet and no task is named, so the total is zero.
    send_command(make_item(CMD_SNAPSHOT, 16'h0000, 32'hFFFF_FFF8, 3'd0));
    // The open interval of the running task wraps past the top of the counter.
    send_command(make_item(CMD_SNAPSHOT, 16'hFFFF, 32'h0000_0010, 3'd0));
    send_command(make_item(CMD_SNAPSHOT, 16'hFFFF, 32'h0000_0010, 3'd1));
    send_command(make_item(CMD_SWITCH_OUT, 16'hFFFF, 32'h0000_0030, 3'd0));
    // A known id is stamped and counted again without a new entry.
    send_command(make_item(CMD_SWITCH_IN, 16'hFFFF, 32'h0000_0100, 3'd0));
    send_command(make_item(CMD_SWITCH_OUT, 16'hFFFF, 32'h0000_0400, 3'd0));
    send_command(make_item(CMD_SWITCH_IN, known_id(1), 32'h0000_0000, 3'd0));
    for (int k = 2; k < MAX_TASKS; k++) begin
      send_command(make_item(CMD_SWITCH_IN, known_id(k), 32'(k * 32'h1000), 3'd0));
    end
    // The table is full now; an unseen id must be refused.
    send_command(make_item(CMD_SWITCH_IN, 16'h0BAD, 32'h0000_9000, 3'd0));
    // The longest possible interval in one go.
    send_command(make_item(CMD_SWITCH_OUT, known_id(1), 32'hFFFF_FFFF, 3'd0));
    send_command(make_item(CMD_SNAPSHOT, known_id(7), 32'h0000_A000, 3'd7));
    send_command(make_item(CMD_SNAPSHOT, 16'h0000, 32'h0000_A000, 3'd1));
    send_command(make_item(CMD_SNAPSHOT, known_id(2), 32'hFFFF_0000, 3'd2));
    send_command(make_item(CMD_SNAPSHOT, 16'h0000, 32'h0000_0000, 3'd3));
  endtask

  // Mostly well-formed traffic: a known task is switched in, snapshots are
  // taken while it runs, then it is switched out. About one command in ten
  // is noise with every field random, which also covers unknown ids,
  // switch-outs of tasks that are not running and the undefined command.
  task automatic random_commands(int count);
    in_item_t it;
    int       pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      // Mostly short steps, now and then a jump anywhere on the counter.
      if ($urandom_range(0, 9) == 0) clock_now = clock_now + $urandom;
      else clock_now = clock_now + $urandom_range(1, 4000);
      if (pick < 10) begin
        it = make_item(2'($urandom_range(0, 3)), 16'($urandom), $urandom,
                       3'($urandom_range(0, 7)));
      end else if (running_task == '0) begin
        running_task = known_id($urandom_range(0, MAX_TASKS - 1));
        it = make_item(CMD_SWITCH_IN, running_task, clock_now, 3'd0);
      end else if (pick < 50) begin
        it = make_item(CMD_SWITCH_OUT, running_task, clock_now, 3'd0);
        running_task = '0;
      end else begin
        it = make_item(CMD_SNAPSHOT, running_task, clock_now, 3'($urandom_range(0, 7)));
      end
      send_command(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    clock_now     = 32'h0001_0000;
    running_task  = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_commands();

    // Four phases of random traffic: no idling, an idle sender, a stalling
    // receiver, then both. Between phases the sender pauses until every
    // result has come back, so the unit also sees an empty pipeline.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      random_commands(PHASE_ITEMS);
      wait_for_results();
    end

    // Every command has been transferred and answered. Keep watching for a
    // while so that an extra result would still be caught.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("task_runtime_accounting_table_unit test passed");
    end else begin
      $display("task_runtime_accounting_table_unit test failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs at most about a tenth of this time, even
  // with the longest snapshots and the heaviest idling on both sides.
  initial begin
    #5_000_000;
    $display("task_runtime_accounting_table_unit test failed");
    $finish;
  end

endmodule
